### src/fla_pkg.sv
package fla_pkg;

	localparam int unsigned DataW = 16;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_ALLOC  = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]       action;
		logic [DataW-1:0] chunk_id;
		logic [DataW-1:0] chunk_size;
		logic [DataW-1:0] request_size;
	} fla_req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [DataW-1:0] found_id;
		logic [DataW-1:0] found_size;
	} fla_rsp_t;

	// ripple passed from the head cell toward the tail
	typedef struct packed {
		logic             seen_fit;
		logic             seen_big;
		logic             seen_id;
		logic [DataW-1:0] got_id;
		logic [DataW-1:0] got_size;
	} fla_chain_t;

	// per-cycle commands broadcast to every cell
	typedef struct packed {
		logic eval;
		logic push;
		logic pull;
		logic is_alloc;
		logic use_fit;
	} fla_ctl_t;

	// one list slot as seen by a neighbor
	typedef struct packed {
		logic             valid;
		logic [DataW-1:0] id;
		logic [DataW-1:0] size;
	} fla_slot_t;

endpackage

### src/fla_cell.sv
module fla_cell import fla_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  fla_ctl_t         ctl,
	input  logic [DataW:0]   round_k,
	input  logic [DataW-1:0] key_id,
	input  fla_slot_t        left,
	input  fla_slot_t        right,
	input  fla_chain_t       chain_in,
	output fla_chain_t       chain_out,
	output fla_slot_t        slot
);

	logic             valid_q;
	logic [DataW-1:0] id_q;
	logic [DataW-1:0] size_q;
	logic             fit_s1, big_s1, idm_s1;

	logic [DataW+1:0] twice_k;
	logic             big_now, fit_now, idm_now;
	logic             hit, seen_before, pick, take_next;

	assign twice_k = {round_k, 1'b0};
	assign big_now = valid_q && ({1'b0, size_q} >= round_k);
	assign fit_now = big_now && ({2'b00, size_q} <= twice_k);
	assign idm_now = valid_q && (id_q == key_id);

	// compare against the incoming request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_s1 <= 1'b0;
			big_s1 <= 1'b0;
			idm_s1 <= 1'b0;
		end else if (ctl.eval) begin
			fit_s1 <= fit_now;
			big_s1 <= big_now;
			idm_s1 <= idm_now;
		end
	end

	always_comb begin
		if (ctl.is_alloc) begin
			hit         = ctl.use_fit ? fit_s1 : big_s1;
			seen_before = ctl.use_fit ? chain_in.seen_fit : chain_in.seen_big;
		end else begin
			hit         = idm_s1;
			seen_before = chain_in.seen_id;
		end
		pick      = hit && !seen_before;
		take_next = hit || seen_before;

		chain_out.seen_fit = chain_in.seen_fit || fit_s1;
		chain_out.seen_big = chain_in.seen_big || big_s1;
		chain_out.seen_id  = chain_in.seen_id  || idm_s1;
		chain_out.got_id   = chain_in.got_id   | (pick ? id_q   : '0);
		chain_out.got_size = chain_in.got_size | (pick ? size_q : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.push) begin
			valid_q <= left.valid;
		end else if (ctl.pull && take_next) begin
			valid_q <= right.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			id_q   <= left.id;
			size_q <= left.size;
		end else if (ctl.pull && take_next) begin
			id_q   <= right.id;
			size_q <= right.size;
		end
	end

	assign slot.valid = valid_q;
	assign slot.id    = id_q;
	assign slot.size  = size_q;

endmodule

### src/free_list_size_class_allocator_core.sv
// First-fit free list allocator with a size-class preference. The list is a
// row of LIST_DEPTH cells, head first; each cell holds one chunk (id, size).
// An insert pushes a chunk in at the head, a remove takes out the first chunk
// with the given id, and an allocate rounds the request up to a multiple of 8
// (k) and hands out the first chunk with k <= size <= 2k, or failing that the
// first chunk with size >= k. Each request has an accept step and an apply
// step: in the accept cycle all cells compare their chunk against the request
// in parallel and register the result; in the apply step a priority ripple
// along the row picks the first hit, the picked chunk is gathered into the
// response register and the cells behind it shift one place toward the head
// (or all cells shift one place toward the tail for an insert). One request is
// in work at a time, so a new request is not taken until the previous one has
// been applied, though it is taken while the previous response still waits
// in the output register; the apply step holds until that register is free.
// The ripple across the row sets the clock limit for large LIST_DEPTH. Status:
// 0 done, 1 nothing found or zero request or unknown id, 2 insert into a full
// list. No clearing pass is needed after reset.
module free_list_size_class_allocator_core import fla_pkg::*; #(
	parameter int unsigned LIST_DEPTH = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	input  fla_req_t req,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output fla_rsp_t rsp
);

	localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);

	// control
	logic            busy_q;
	logic [CntW-1:0] count_q;
	logic            rsp_valid_q;
	fla_rsp_t        rsp_q;

	// request held for the apply step
	logic [1:0]       action_s1;
	logic [DataW-1:0] chunk_id_s1;
	logic [DataW-1:0] chunk_size_s1;
	logic             zero_s1;

	logic             accept, apply, full, found;
	logic [DataW:0]   round_k;
	fla_ctl_t         ctl;
	fla_chain_t       chain [LIST_DEPTH+1];
	fla_slot_t        slots [LIST_DEPTH+1];
	fla_slot_t        head_in;
	fla_rsp_t         rsp_next;

	assign accept    = req_valid && req_ready;
	assign req_ready = !busy_q;
	assign apply     = busy_q && (!rsp_valid_q || rsp_ready);
	assign full      = (count_q == CntW'(LIST_DEPTH));

	// round the request up to a multiple of 8; 17 bits so 65529..65535 give 65536
	assign round_k = ({1'b0, req.request_size} + (DataW+1)'(7)) & ~((DataW+1)'(7));

	// head of the ripple: nothing seen yet
	assign chain[0] = '0;

	// new chunk enters at the head; an empty slot enters at the tail
	assign head_in.valid = 1'b1;
	assign head_in.id    = chunk_id_s1;
	assign head_in.size  = chunk_size_s1;
	assign slots[LIST_DEPTH] = '0;

	// decide what the row does in the apply step
	always_comb begin
		ctl.eval     = accept;
		ctl.is_alloc = (action_s1 == ACT_ALLOC);
		ctl.use_fit  = chain[LIST_DEPTH].seen_fit;
		ctl.push     = 1'b0;
		ctl.pull     = 1'b0;
		found        = 1'b0;
		rsp_next     = '0;
		rsp_next.status = ST_DONE;
		unique case (action_s1)
			ACT_INSERT: begin
				ctl.push = apply && !full;
				rsp_next.status = full ? ST_FULL : ST_DONE;
			end
			ACT_ALLOC: begin
				found = !zero_s1 && (chain[LIST_DEPTH].seen_fit || chain[LIST_DEPTH].seen_big);
				ctl.pull = apply && found;
				rsp_next.status = found ? ST_DONE : ST_NONE;
				if (found) begin
					rsp_next.found_id   = chain[LIST_DEPTH].got_id;
					rsp_next.found_size = chain[LIST_DEPTH].got_size;
				end
			end
			ACT_REMOVE: begin
				found = chain[LIST_DEPTH].seen_id;
				ctl.pull = apply && found;
				rsp_next.status = found ? ST_DONE : ST_NONE;
			end
			default: begin
				// unused action: report done, touch nothing
				rsp_next.status = ST_DONE;
			end
		endcase
	end

	genvar gi;
	generate
		for (gi = 0; gi < LIST_DEPTH; gi++) begin : g_cell
			fla_cell u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.ctl       (ctl),
				.round_k   (round_k),
				.key_id    (req.chunk_id),
				.left      ((gi == 0) ? head_in : slots[(gi == 0) ? 0 : gi-1]),
				.right     (slots[gi+1]),
				.chain_in  (chain[gi]),
				.chain_out (chain[gi+1]),
				.slot      (slots[gi])
			);
		end
	endgenerate

	// hold the request for the apply step
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1     <= req.action;
			chunk_id_s1   <= req.chunk_id;
			chunk_size_s1 <= req.chunk_size;
			zero_s1       <= (req.request_size == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (apply) begin
				busy_q <= 1'b0;
			end
			// update the fill count: up on a push, down on a pull
			if (ctl.push) begin
				count_q <= count_q + CntW'(1);
			end else if (ctl.pull) begin
				count_q <= count_q - CntW'(1);
			end
			if (apply) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (apply) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// fill count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(LIST_DEPTH))
		else $error("fill count above list depth");

	// a successful insert grows the list by one
	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |=> count_q == $past(count_q) + CntW'(1))
		else $error("insert did not grow the list");

	// a response appears only at the end of a request in work
	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(busy_q))
		else $error("response without a request in work");

	// the head cell holds a chunk whenever the list is not empty
	a_head_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0) |-> slots[0].valid)
		else $error("non-empty list with empty head cell");

endmodule

### dv/tb.sv
module tb import fla_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned LIST_DEPTH = 16;
	// action code with no operation behind it; the core answers done with zeros
	localparam logic [1:0] ACT_SPARE = 2'd3;
	// give up after this many cycles in which neither channel moves a request
	localparam int QUIET_LIMIT = 2000;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     req_valid = 1'b0;
	logic     req_ready;
	fla_req_t req       = '0;
	logic     rsp_valid;
	logic     rsp_ready = 1'b0;
	fla_rsp_t rsp;

	// shadow of the free list, head at index 0
	logic [DataW-1:0] list_ids   [LIST_DEPTH];
	logic [DataW-1:0] list_sizes [LIST_DEPTH];
	int               list_len = 0;

	// responses owed by the core, oldest first
	fla_rsp_t awaited_replies [$];

	int mismatches   = 0;
	int quiet_cycles = 0;
	int stall_left   = 0;
	bit tx_idle_on   = 1'b1;
	bit rx_idle_on   = 1'b1;

	free_list_size_class_allocator_core #(
		.LIST_DEPTH(LIST_DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	always #4ns clk = ~clk;

	// ---------------------------------------------------------------------
	// Shadow list model
	// ---------------------------------------------------------------------

	// Close the gap left at pos by moving the tail one place toward the head.
	function automatic void drop_entry(input int pos);
		int i;
		for (i = pos; i + 1 < list_len; i++) begin
			list_ids[i]   = list_ids[i + 1];
			list_sizes[i] = list_sizes[i + 1];
		end
		list_len--;
	endfunction

	// Apply one request to the shadow list and return the response it owes.
	function automatic fla_rsp_t step_free_list(input fla_req_t r);
		fla_rsp_t    o;
		int          i;
		int          pick;
		int unsigned k;
		int unsigned sz;
		o      = '0;
		o.status = ST_DONE;
		pick   = -1;
		case (r.action)
			ACT_INSERT: begin
				// refuse when full, otherwise push in at the head
				if (list_len >= LIST_DEPTH) begin
					o.status = ST_FULL;
				end else begin
					for (i = list_len; i > 0; i--) begin
						list_ids[i]   = list_ids[i - 1];
						list_sizes[i] = list_sizes[i - 1];
					end
					list_ids[0]   = r.chunk_id;
					list_sizes[0] = r.chunk_size;
					list_len++;
				end
			end
			ACT_ALLOC: begin
				if (r.request_size == '0) begin
					o.status = ST_NONE;
				end else begin
					// round up to a multiple of 8; may reach 65536
					k = (int'(r.request_size) + 7) & ~32'd7;
					// first pass: size class k..2k
					for (i = 0; i < list_len && pick < 0; i++) begin
						sz = 32'(list_sizes[i]);
						if (sz >= k && sz <= 2 * k)
							pick = i;
					end
					// second pass: anything big enough
					for (i = 0; i < list_len && pick < 0; i++) begin
						sz = 32'(list_sizes[i]);
						if (sz >= k)
							pick = i;
					end
					if (pick < 0) begin
						o.status = ST_NONE;
					end else begin
						o.found_id   = list_ids[pick];
						o.found_size = list_sizes[pick];
						drop_entry(pick);
					end
				end
			end
			ACT_REMOVE: begin
				// take out only the copy nearest the head
				for (i = 0; i < list_len && pick < 0; i++) begin
					if (list_ids[i] == r.chunk_id)
						pick = i;
				end
				if (pick < 0)
					o.status = ST_NONE;
				else
					drop_entry(pick);
			end
			default: begin
				// spare action: nothing changes, zero response
			end
		endcase
		return o;
	endfunction

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	function automatic fla_req_t make_req(input logic [1:0] act, input int unsigned id,
			input int unsigned csize, input int unsigned rsize);
		fla_req_t r;
		r.action       = act;
		r.chunk_id     = id[DataW-1:0];
		r.chunk_size   = csize[DataW-1:0];
		r.request_size = rsize[DataW-1:0];
		return r;
	endfunction

	// Mostly short gaps, now and then a long one.
	function automatic int pick_gap();
		int roll;
		if (!tx_idle_on)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Favor a small id pool so duplicates show up often.
	function automatic int unsigned rand_chunk_id();
		if ($urandom_range(0, 99) < 60)
			return $urandom_range(0, 31);
		return $urandom_range(0, 65535);
	endfunction

	function automatic int unsigned rand_chunk_size();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return $urandom_range(0, 600);
		if (roll < 85)
			return 8 * $urandom_range(1, 64);
		return $urandom_range(0, 65535);
	endfunction

	// Request sized against a chunk on the list, so both the size-class pass
	// and the fallback pass get hit; sometimes a size picked blindly.
	function automatic int unsigned rand_request_size();
		int unsigned s;
		if (list_len > 0 && $urandom_range(0, 99) < 75) begin
			s = 32'(list_sizes[$urandom_range(0, list_len - 1)]);
			if (s < 8)
				return $urandom_range(0, 8);
			return $urandom_range(s / 3, s);
		end
		if ($urandom_range(0, 1) == 0)
			return $urandom_range(0, 700);
		return $urandom_range(0, 65535);
	endfunction

	// Present one request, hold it until accepted, then queue its response.
	// Called right after a rising edge; valid stays high if no gap follows.
	task automatic send_request(input fla_req_t item);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= item;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		awaited_replies.push_back(step_free_list(item));
	endtask

	// Stop sending and wait until every owed response has come back.
	task automatic hold_until_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (awaited_replies.size() != 0)
			@(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// Hit field extremes, every action and the listed corner cases in order.
	task automatic test_corner_cases();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		// empty list: allocate and remove find nothing
		send_request(make_req(ACT_ALLOC, 16'hFFFF, 16'hFFFF, 0));
		send_request(make_req(ACT_ALLOC, 0, 0, 8));
		send_request(make_req(ACT_REMOVE, 5, 0, 0));
		send_request(make_req(ACT_SPARE, 16'hFFFF, 16'hFFFF, 16'hFFFF));
		// extremes of id and size, plus a duplicate id
		send_request(make_req(ACT_INSERT, 16'hFFFF, 16'hFFFF, 0));
		send_request(make_req(ACT_INSERT, 0, 0, 16'hFFFF));
		send_request(make_req(ACT_INSERT, 16'h1234, 40, 0));
		send_request(make_req(ACT_INSERT, 16'h1234, 100, 0));
		send_request(make_req(ACT_INSERT, 7, 24, 0));
		// zero request and a request that rounds past 16 bits
		send_request(make_req(ACT_ALLOC, 0, 0, 0));
		send_request(make_req(ACT_ALLOC, 0, 0, 16'hFFFF));
		// duplicate: only the copy nearest the head (size 100) goes
		send_request(make_req(ACT_REMOVE, 16'h1234, 0, 0));
		// k=8: nothing in 8..16, first big enough is 7/24
		send_request(make_req(ACT_ALLOC, 0, 0, 1));
		// k=24: 40 sits in the 24..48 class
		send_request(make_req(ACT_ALLOC, 0, 0, 17));
		send_request(make_req(ACT_REMOVE, 16'hBEEF, 0, 0));
		// k=65528 still fits the largest chunk
		send_request(make_req(ACT_ALLOC, 0, 0, 65528));
		send_request(make_req(ACT_SPARE, 0, 0, 0));
		send_request(make_req(ACT_REMOVE, 0, 0, 0));
		send_request(make_req(ACT_INSERT, 1, 16'hFFFF, 0));
		send_request(make_req(ACT_ALLOC, 0, 0, 65529));
		send_request(make_req(ACT_ALLOC, 0, 0, 65521));
		send_request(make_req(ACT_REMOVE, 1, 0, 0));
	endtask

	// Fill the list, overflow it, pause for the core to drain, then empty it.
	task automatic test_fill_and_overflow();
		int round;
		int n;
		for (round = 0; round < 3; round++) begin
			tx_idle_on = (round != 1);
			rx_idle_on = (round != 2);
			while (list_len < LIST_DEPTH)
				send_request(make_req(ACT_INSERT, rand_chunk_id(),
					rand_chunk_size(), $urandom_range(0, 65535)));
			for (n = 0; n < 3; n++)
				send_request(make_req(ACT_INSERT, rand_chunk_id(),
					rand_chunk_size(), $urandom_range(0, 65535)));
			// let every response land before touching the full list again
			hold_until_drained();
			while (list_len > 0) begin
				if ($urandom_range(0, 1) == 0)
					send_request(make_req(ACT_ALLOC, $urandom_range(0, 65535),
						$urandom_range(0, 65535), rand_request_size()));
				else
					send_request(make_req(ACT_REMOVE,
						32'(list_ids[$urandom_range(0, list_len - 1)]),
						$urandom_range(0, 65535), $urandom_range(0, 65535)));
			end
			send_request(make_req(ACT_ALLOC, 0, 0, rand_request_size()));
			send_request(make_req(ACT_REMOVE, rand_chunk_id(), 0, 0));
		end
	endtask

	// Mostly well-formed traffic around a half-full list, with some noise.
	task automatic test_random_traffic(input int count);
		int       idx;
		int       roll;
		int       ins_weight;
		fla_req_t item;
		for (idx = 0; idx < count; idx++) begin
			// cycle idle modes every hundred requests
			case ((idx / 100) % 4)
				0: begin
					tx_idle_on = 1'b0;
					rx_idle_on = 1'b0;
				end
				1: begin
					tx_idle_on = 1'b1;
					rx_idle_on = 1'b1;
				end
				2: begin
					tx_idle_on = 1'b1;
					rx_idle_on = 1'b0;
				end
				default: begin
					tx_idle_on = 1'b0;
					rx_idle_on = 1'b1;
				end
			endcase
			ins_weight = (list_len < 8) ? 55 : 35;
			roll = $urandom_range(0, 99);
			if (roll < 6) begin
				// noise: every field at random, spare action included
				item = make_req(2'($urandom_range(0, 3)), $urandom_range(0, 65535),
					$urandom_range(0, 65535), $urandom_range(0, 65535));
			end else if (roll < 6 + ins_weight) begin
				item = make_req(ACT_INSERT, rand_chunk_id(), rand_chunk_size(),
					$urandom_range(0, 65535));
			end else if (roll < 6 + ins_weight + 25 || list_len == 0) begin
				item = make_req(ACT_ALLOC, $urandom_range(0, 65535),
					$urandom_range(0, 65535), rand_request_size());
			end else begin
				// mostly ids on the list, sometimes a stranger
				item = make_req(ACT_REMOVE,
					($urandom_range(0, 9) < 8) ? int'(list_ids[$urandom_range(0, list_len - 1)])
						: rand_chunk_id(),
					$urandom_range(0, 65535), $urandom_range(0, 65535));
			end
			send_request(item);
		end
	endtask

	// ---------------------------------------------------------------------
	// Response side: stall, check, watchdog
	// ---------------------------------------------------------------------

	// Stall rsp_ready at random; short stalls mostly, a few long ones.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			rsp_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (rx_idle_on && $urandom_range(0, 99) < 25) begin
			rsp_ready  <= 1'b0;
			stall_left <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
				: $urandom_range(7, 39);
		end else begin
			rsp_ready <= 1'b1;
		end
	end

	function automatic void note_mismatch(input string what, input fla_rsp_t want);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s: expected status %0d id %h size %h, got status %0d id %h size %h",
				$realtime, what, want.status, want.found_id, want.found_size,
				rsp.status, rsp.found_id, rsp.found_size);
	endfunction

	// Compare each accepted response with the oldest owed one.
	always @(posedge clk) begin
		fla_rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (awaited_replies.size() == 0) begin
					note_mismatch("response with no request pending", '0);
				end else begin
					want = awaited_replies.pop_front();
					if (rsp.status != want.status)
						note_mismatch("status differs", want);
					else if (rsp.found_id != want.found_id)
						note_mismatch("found_id differs", want);
					else if (rsp.found_size != want.found_size)
						note_mismatch("found_size differs", want);
				end
			end
			// count cycles with no request moving on either channel
			if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $realtime, QUIET_LIMIT);
				$display("free_list_size_class_allocator_core test failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------------

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_cases();
		test_fill_and_overflow();
		test_random_traffic(1300);

		// drain, then watch a while longer for stray responses
		req_valid <= 1'b0;
		while (awaited_replies.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (mismatches == 0 && awaited_replies.size() == 0)
			$display("free_list_size_class_allocator_core test passed");
		else
			$display("free_list_size_class_allocator_core test failed");
		$finish;
	end

endmodule
